// ----- design/rlsd_pkg.sv -----
// Shared types, codes and constants of the RGB LED strip driver.
// No dependencies; every other design file refers to this package.
package rlsd_pkg;

    localparam int DEF_MAX_LEDS   = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int BITS_PER_LED   = 24;

    localparam int NUM_LEDS_W     = 7;
    localparam int TICKS_W        = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [NUM_LEDS_W-1:0] RST_NUM_LEDS    = 7'd2;
    localparam logic [TICKS_W-1:0]    RST_ZERO_HIGH   = 8'd5;
    localparam logic [TICKS_W-1:0]    RST_ONE_HIGH    = 8'd14;
    localparam logic [TICKS_W-1:0]    RST_BIT_PERIOD  = 8'd20;

    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_LEDS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_HIGH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD = 2'd3;

    localparam logic [2:0] MODE_SET   = 3'd0;
    localparam logic [2:0] MODE_FILL  = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_START = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_FILL    = 3'd1;
    localparam logic [2:0] OP_CLEAR   = 3'd2;
    localparam logic [2:0] OP_START   = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_NONE    = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_BUSY  = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  pixel_index;
        logic [23:0] color;
    } item_t;

    typedef struct packed {
        logic [NUM_LEDS_W-1:0] strip_len;
        logic [TICKS_W-1:0]    zero_high_ticks;
        logic [TICKS_W-1:0]    one_high_ticks;
        logic [TICKS_W-1:0]    bit_period_ticks;
    } cfg_t;

endpackage

// ----- design/rlsd_front.sv -----
// Front end: accepts input words, decodes the mode into an operation code.
// Depends on rlsd_pkg; feeds rlsd_queue.
module rlsd_front
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,
    input  logic [2:0]          s_tuser,
    input  logic                queue_full,
    input  logic                init_done,
    output logic                push,
    output rlsd_pkg::item_t     item
);

    logic [2:0] op;

    always_comb
    begin
        unique case (s_tuser)
            rlsd_pkg::MODE_SET:   op = rlsd_pkg::OP_SET;
            rlsd_pkg::MODE_FILL:  op = rlsd_pkg::OP_FILL;
            rlsd_pkg::MODE_CLEAR: op = rlsd_pkg::OP_CLEAR;
            rlsd_pkg::MODE_START: op = rlsd_pkg::OP_START;
            rlsd_pkg::MODE_TICK:  op = rlsd_pkg::OP_TICK;
            default:              op = rlsd_pkg::OP_NONE;
        endcase
    end

    assign s_tready         = init_done && !queue_full;
    assign push             = s_tvalid && s_tready;
    assign item.op          = op;
    assign item.pixel_index = s_tdata[7:0];
    assign item.color       = s_tdata[31:8];

endmodule

// ----- design/rlsd_queue.sv -----
// Short queue of decoded words between the front end and the back end.
// Depends on rlsd_pkg for the word type and depth.
module rlsd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rlsd_pkg::item_t     push_item,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output rlsd_pkg::item_t     head
);

    localparam int DEPTH = rlsd_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    rlsd_pkg::item_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/rlsd_back.sv -----
// Back end: pixel store, store sweeps, line waveform sequencer, result register.
// Depends on rlsd_pkg; pops words from rlsd_queue.
module rlsd_back
#(
    parameter int MAX_LEDS = rlsd_pkg::DEF_MAX_LEDS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rlsd_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  rlsd_pkg::item_t     q_item,
    output logic                pop,
    output logic                init_done,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int LW = $clog2(MAX_LEDS + 1);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic [23:0]  mem [MAX_LEDS];
    logic [23:0]  rd_data_reg;

    logic         state_reg, state_next;
    logic         init_done_reg, init_done_next;
    logic [LW-1:0] sweep_pos_reg, sweep_pos_next;
    logic [LW-1:0] sweep_end_reg, sweep_end_next;
    logic [23:0]  sweep_data_reg, sweep_data_next;

    logic [LW-1:0] led_pos_reg, led_pos_next;
    logic [4:0]   bit_pos_reg, bit_pos_next;
    logic [7:0]   tick_reg, tick_next;
    logic         busy_reg, busy_next;

    logic         out_valid_reg;
    logic [1:0]   out_status_reg;
    logic         out_line_reg;
    logic         out_sending_reg;

    logic [LW-1:0] count;
    logic [1:0]   status;
    logic         line;
    logic         we;
    logic [AW-1:0] waddr;
    logic [23:0]  wdata;
    logic [AW-1:0] raddr;
    logic [23:0]  grb;
    logic         cur_bit;
    logic [7:0]   high_ticks;
    logic [8:0]   tick_inc;
    logic [4:0]   bit_inc;
    logic [LW-1:0] led_inc;
    logic [LW-1:0] sweep_inc;

    assign count = ({25'd0, cfg.strip_len} > 32'(MAX_LEDS)) ? LW'(MAX_LEDS) : LW'(cfg.strip_len);
    assign pop   = (state_reg == ST_RUN) && q_valid && (!out_valid_reg || m_tready);

    assign grb        = {rd_data_reg[15:8], rd_data_reg[23:16], rd_data_reg[7:0]};
    assign cur_bit    = grb[5'd23 - bit_pos_reg];
    assign high_ticks = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
    assign tick_inc   = {1'b0, tick_reg} + 9'd1;
    assign bit_inc    = bit_pos_reg + 5'd1;
    assign led_inc    = LW'(led_pos_reg + 1'b1);
    assign sweep_inc  = LW'(sweep_pos_reg + 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        init_done_next  = init_done_reg;
        sweep_pos_next  = sweep_pos_reg;
        sweep_end_next  = sweep_end_reg;
        sweep_data_next = sweep_data_reg;
        led_pos_next    = led_pos_reg;
        bit_pos_next    = bit_pos_reg;
        tick_next       = tick_reg;
        busy_next       = busy_reg;
        status          = rlsd_pkg::STATUS_OK;
        line            = 1'b0;
        we              = 1'b0;
        waddr           = sweep_pos_reg[AW-1:0];
        wdata           = sweep_data_reg;

        if (state_reg == ST_SWEEP)
        begin
            we             = 1'b1;
            sweep_pos_next = sweep_inc;
            if (sweep_inc == sweep_end_reg)
            begin
                state_next     = ST_RUN;
                init_done_next = 1'b1;
            end
        end
        else if (pop)
        begin
            if (q_item.op == rlsd_pkg::OP_TICK)
            begin
                if (busy_reg && ({{(32-LW){1'b0}}, led_pos_reg} < 32'(MAX_LEDS))
                    && (bit_pos_reg < 5'd24))
                begin
                    line = (tick_reg < high_ticks);
                    if (tick_inc >= {1'b0, cfg.bit_period_ticks})
                    begin
                        tick_next = '0;
                        if (bit_inc >= 5'd24)
                        begin
                            bit_pos_next = '0;
                            led_pos_next = led_inc;
                            if (led_inc >= count)
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        else
                        begin
                            bit_pos_next = bit_inc;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc[7:0];
                    end
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            else if (busy_reg)
            begin
                status = rlsd_pkg::STATUS_BUSY;
            end
            else
            begin
                case (q_item.op)
                    rlsd_pkg::OP_SET:
                    begin
                        if ({24'd0, q_item.pixel_index} < 32'(count))
                        begin
                            we    = 1'b1;
                            waddr = AW'(q_item.pixel_index);
                            wdata = q_item.color;
                        end
                        else
                        begin
                            status = rlsd_pkg::STATUS_RANGE;
                        end
                    end
                    rlsd_pkg::OP_FILL, rlsd_pkg::OP_CLEAR:
                    begin
                        if (count != '0)
                        begin
                            state_next      = ST_SWEEP;
                            sweep_pos_next  = '0;
                            sweep_end_next  = count;
                            sweep_data_next = (q_item.op == rlsd_pkg::OP_FILL) ? q_item.color
                                                                                : 24'd0;
                        end
                    end
                    rlsd_pkg::OP_START:
                    begin
                        led_pos_next = '0;
                        bit_pos_next = '0;
                        tick_next    = '0;
                        busy_next    = (count != '0);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign raddr = ({{(32-LW){1'b0}}, led_pos_next} < 32'(MAX_LEDS)) ? led_pos_next[AW-1:0]
                                                                     : '0;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            init_done_reg  <= 1'b0;
            sweep_pos_reg  <= '0;
            sweep_end_reg  <= LW'(MAX_LEDS);
            sweep_data_reg <= '0;
            led_pos_reg    <= '0;
            bit_pos_reg    <= '0;
            tick_reg       <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_done_reg  <= init_done_next;
            sweep_pos_reg  <= sweep_pos_next;
            sweep_end_reg  <= sweep_end_next;
            sweep_data_reg <= sweep_data_next;
            led_pos_reg    <= led_pos_next;
            bit_pos_reg    <= bit_pos_next;
            tick_reg       <= tick_next;
            busy_reg       <= busy_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg  <= status;
            out_line_reg    <= line;
            out_sending_reg <= busy_reg || busy_next;
        end
    end

    assign init_done = init_done_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_sending_reg, out_line_reg, out_status_reg};

    a_busy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({{(32-LW){1'b0}}, led_pos_reg} < 32'(MAX_LEDS)) && (bit_pos_reg < 5'd24))
        else $error("transfer position out of range");

    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !pop)
        else $error("word taken during a store sweep");

    a_line_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_line_reg) |-> (out_status_reg == rlsd_pkg::STATUS_OK)
            && out_sending_reg)
        else $error("line high without an active transfer");

    a_no_busy_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !busy_reg)
        else $error("store sweep during a transfer");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> out_valid_reg && $stable(m_tdata))
        else $error("stalled result lost");

endmodule

// ----- design/rgb_led_strip_driver.sv -----
// RGB LED strip driver top level: configuration registers and the three stages.
// Depends on rlsd_pkg, rlsd_front, rlsd_queue and rlsd_back.
//
// Each input word gives exactly one result word, in order. Set pixel, start,
// tick and undefined modes need no store sweep in the back end, so ticks can
// stream at one word per clock while m_tready is high. Fill and clear occupy
// the single write port of the pixel store while they sweep every LED in use
// (saturated LED count); words sent meanwhile wait in the two-entry queue.
// After reset a sweep over all MAX_LEDS entries clears the store, during which
// s_tready stays low; configuration writes are taken at any time. A result waits in an
// output register, so a stalled m_tready does not block acceptance of the next word.
module rgb_led_strip_driver
#(
    parameter int MAX_LEDS = rlsd_pkg::DEF_MAX_LEDS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,    // pixel_index[7:0], color[31:8]
    input  logic [2:0]                          s_tuser,    // mode[2:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,    // status[1:0], line_level[2],
                                                            // sending[3], zero[7:4]
    input  logic                                cfg_we,
    input  logic [rlsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rlsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    rlsd_pkg::cfg_t  cfg_reg;
    rlsd_pkg::item_t push_item;
    rlsd_pkg::item_t head;
    logic            push;
    logic            pop;
    logic            queue_full;
    logic            queue_valid;
    logic            init_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strip_len        <= rlsd_pkg::RST_NUM_LEDS;
            cfg_reg.zero_high_ticks  <= rlsd_pkg::RST_ZERO_HIGH;
            cfg_reg.one_high_ticks   <= rlsd_pkg::RST_ONE_HIGH;
            cfg_reg.bit_period_ticks <= rlsd_pkg::RST_BIT_PERIOD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlsd_pkg::CFG_NUM_LEDS:
                    cfg_reg.strip_len <= cfg_wdata[rlsd_pkg::NUM_LEDS_W-1:0];
                rlsd_pkg::CFG_ZERO_HIGH:
                    cfg_reg.zero_high_ticks <= cfg_wdata;
                rlsd_pkg::CFG_ONE_HIGH:
                    cfg_reg.one_high_ticks <= cfg_wdata;
                rlsd_pkg::CFG_BIT_PERIOD:
                    cfg_reg.bit_period_ticks <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    rlsd_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .init_done  (init_done),
        .push       (push),
        .item       (push_item)
    );

    rlsd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .not_empty  (queue_valid),
        .head       (head)
    );

    rlsd_back #(.MAX_LEDS(MAX_LEDS)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (queue_valid),
        .q_item     (head),
        .pop        (pop),
        .init_done  (init_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
